// ----- sv/hrfw_pkg.sv -----
// ----------------------------------------------------------------------------
// hrfw_pkg
// Shared types, constants and the character decoder for the hex record unit.
// ----------------------------------------------------------------------------
package hrfw_pkg;

    localparam logic [7:0]  NEWLINE        = 8'd10;
    localparam logic [5:0]  POS_COUNT_HI   = 6'd1;
    localparam logic [5:0]  POS_COUNT_LO   = 6'd2;
    localparam logic [5:0]  POS_KIND_HI    = 6'd7;
    localparam logic [5:0]  POS_KIND_LO    = 6'd8;
    localparam logic [5:0]  DATA_START     = 6'd9;
    localparam logic [5:0]  POS_MAX        = 6'd63;
    localparam logic [7:0]  KIND_DATA      = 8'h00;
    localparam int          RECORD_NIBBLES = 32;
    localparam int          RECORD_BITS    = 4 * RECORD_NIBBLES;
    localparam logic [31:0] BASE_RESET     = 32'h0801_0000;
    localparam logic [31:0] ADDR_STEP      = 32'd4;
    localparam logic [1:0]  LAST_WORD      = 2'd3;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

    function automatic logic [3:0] hex_value(input logic [7:0] ch);
        logic [3:0] v;
        v = 4'd0;
        if (ch inside {[8'h30:8'h39]}) begin
            v = 4'(ch - 8'h30);
        end else if (ch inside {[8'h41:8'h46]}) begin
            v = 4'(ch - 8'h37);
        end
        return v;
    endfunction

endpackage

// ----- sv/hrfw_front.sv -----
// ----------------------------------------------------------------------------
// hrfw_front
// Line parser: tracks position in the line, captures count, type and data
// nibbles, and hands a finished data record to the queue on newline.
// ----------------------------------------------------------------------------
module hrfw_front #(
    parameter int DATA_NIBBLES = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [7:0]                       i_char_code,
    output logic                             o_push,
    output logic [hrfw_pkg::RECORD_BITS-1:0] o_record
);

    localparam int STORED = (DATA_NIBBLES < hrfw_pkg::RECORD_NIBBLES) ?
                            DATA_NIBBLES : hrfw_pkg::RECORD_NIBBLES;
    localparam int IW = $clog2(STORED);

    logic [5:0]              r_pos;
    logic [7:0]              r_count;
    logic [7:0]              r_kind;
    logic [STORED-1:0][3:0]  r_nib;

    logic [3:0] d;
    logic [5:0] idx;
    logic       store;
    logic       newline;

    assign d       = hrfw_pkg::hex_value(i_char_code);
    assign idx     = r_pos - hrfw_pkg::DATA_START;
    assign newline = (i_char_code == hrfw_pkg::NEWLINE);
    assign store   = (r_pos >= hrfw_pkg::DATA_START)
                   && ({3'd0, idx} < {r_count, 1'b0})
                   && (idx < 6'(STORED));
    assign o_push  = i_accept && newline && (r_kind == hrfw_pkg::KIND_DATA);

    for (genvar j = 0; j < hrfw_pkg::RECORD_NIBBLES; j++) begin : g_rec
        if (j < STORED) begin : g_on
            assign o_record[4*j +: 4] = r_nib[j];
        end else begin : g_off
            assign o_record[4*j +: 4] = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_kind  <= '0;
            r_nib   <= '0;
        end else if (i_accept) begin
            if (newline) begin
                r_pos   <= '0;
                r_count <= '0;
                r_kind  <= '0;
                r_nib   <= '0;
            end else begin
                case (r_pos)
                    hrfw_pkg::POS_COUNT_HI: r_count <= {d, 4'd0};
                    hrfw_pkg::POS_COUNT_LO: r_count <= r_count | {4'd0, d};
                    hrfw_pkg::POS_KIND_HI:  r_kind  <= {d, 4'd0};
                    hrfw_pkg::POS_KIND_LO:  r_kind  <= r_kind | {4'd0, d};
                    default: begin
                        if (store) begin
                            r_nib[idx[IW-1:0]] <= d;
                        end
                    end
                endcase
                if (r_pos != hrfw_pkg::POS_MAX) begin
                    r_pos <= r_pos + 6'd1;
                end
            end
        end
    end

endmodule

// ----- sv/hrfw_fifo.sv -----
// ----------------------------------------------------------------------------
// hrfw_fifo
// Two-entry record queue between the line parser and the word sequencer.
// ----------------------------------------------------------------------------
module hrfw_fifo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_push,
    input  logic [hrfw_pkg::RECORD_BITS-1:0] i_data,
    input  logic                             i_pop,
    output logic [hrfw_pkg::RECORD_BITS-1:0] o_data,
    output hrfw_pkg::t_fifo_stat             o_stat
);

    logic [hrfw_pkg::RECORD_BITS-1:0] r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_data       = r_mem[r_rp];
    assign o_stat.full  = (r_cnt == 2'd2);
    assign o_stat.empty = (r_cnt == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- sv/hrfw_back.sv -----
// ----------------------------------------------------------------------------
// hrfw_back
// Word sequencer: slices the head record into four little-endian words,
// stamps the running flash address and drives the output register.
// ----------------------------------------------------------------------------
module hrfw_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [31:0]                      i_cfg_wdata,
    input  logic [hrfw_pkg::RECORD_BITS-1:0] i_record,
    input  hrfw_pkg::t_fifo_stat             i_stat,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [31:0]                      o_flash_address,
    output logic [31:0]                      o_data_word,
    output logic                             o_last_of_record
);

    logic [1:0]  r_k;
    logic [31:0] r_waddr;
    logic        r_valid;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic        r_last;

    logic        load;
    logic [31:0] n_data;
    logic [4:0]  nb;

    assign load  = (!r_valid || i_ready) && !i_stat.empty;
    assign o_pop = load && (r_k == hrfw_pkg::LAST_WORD);

    always_comb begin
        n_data = '0;
        nb     = '0;
        for (int b = 0; b < 4; b++) begin
            nb = {r_k, 3'd0} + 5'(2 * b);
            n_data[8*b +: 8] = {i_record[4*nb +: 4], i_record[4*(nb + 5'd1) +: 4]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_waddr <= hrfw_pkg::BASE_RESET;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k     <= r_k + 2'd1;
                r_valid <= 1'b1;
                r_addr  <= r_waddr;
                r_data  <= n_data;
                r_last  <= (r_k == hrfw_pkg::LAST_WORD);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_waddr <= i_cfg_wdata;
            end else if (load) begin
                r_waddr <= r_waddr + hrfw_pkg::ADDR_STEP;
            end
        end
    end

    assign o_valid          = r_valid;
    assign o_flash_address  = r_addr;
    assign o_data_word      = r_data;
    assign o_last_of_record = r_last;

endmodule

// ----- sv/hex_record_to_flash_words_unit.sv -----
// ----------------------------------------------------------------------------
// hex_record_to_flash_words_unit
// Intel HEX text to flash program words.
// ----------------------------------------------------------------------------
// Input channel: one character per word on i_char_code (i_char_valid /
// o_char_ready). Output channel: flash address, 32-bit data word and a
// last-of-record flag (o_word_valid / i_word_ready). i_cfg_we loads the
// base address and restarts the running address from it.
// A character is taken every cycle while the two-entry record queue has
// room; fields are captured by their position in the line.
// A newline ending a type-0 record queues it; four words follow, the first
// after the record passes the queue and the output register when the
// sequencer is idle, then one per cycle while the receiver takes them. The word
// sequencer emits one word per cycle unless stalled; a record is four words.
// A receiver stall holds the output register, then fills the queue; input
// ready drops only when two records wait.
// Reset clears the line state and queue, empties the output and sets the
// running address to 0x08010000.
// ----------------------------------------------------------------------------
module hex_record_to_flash_words_unit #(
    parameter int DATA_NIBBLES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_char_valid,
    output logic        o_char_ready,
    input  logic [7:0]  i_char_code,
    output logic        o_word_valid,
    input  logic        i_word_ready,
    output logic [31:0] o_flash_address,
    output logic [31:0] o_data_word,
    output logic        o_last_of_record
);

    logic                             accept;
    logic                             push;
    logic                             pop;
    logic [hrfw_pkg::RECORD_BITS-1:0] rec_in;
    logic [hrfw_pkg::RECORD_BITS-1:0] rec_head;
    hrfw_pkg::t_fifo_stat             stat;

    assign o_char_ready = !stat.full;
    assign accept       = i_char_valid && o_char_ready;

    hrfw_front #(
        .DATA_NIBBLES(DATA_NIBBLES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_char_code (i_char_code),
        .o_push      (push),
        .o_record    (rec_in)
    );

    hrfw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (rec_in),
        .i_pop   (pop),
        .o_data  (rec_head),
        .o_stat  (stat)
    );

    hrfw_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_record         (rec_head),
        .i_stat           (stat),
        .o_pop            (pop),
        .o_valid          (o_word_valid),
        .i_ready          (i_word_ready),
        .o_flash_address  (o_flash_address),
        .o_data_word      (o_data_word),
        .o_last_of_record (o_last_of_record)
    );

endmodule

// ----- sv/hrfw_checker.sv -----
// ----------------------------------------------------------------------------
// hrfw_checker
// Port-level checks for the hex record unit, bound to the top level.
// ----------------------------------------------------------------------------
module hrfw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_word_valid,
    input logic        i_word_ready,
    input logic [31:0] o_flash_address,
    input logic [31:0] o_data_word,
    input logic        o_last_of_record
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_word_valid)
        else $error("output valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && !i_word_ready |=>
            o_word_valid && $stable(o_flash_address) && $stable(o_data_word)
            && $stable(o_last_of_record))
        else $error("stalled word changed");

    a_record_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && i_word_ready && !o_last_of_record |=> o_word_valid)
        else $error("record words not back to back");

    a_addr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word_valid && i_word_ready && !o_last_of_record |=>
            o_flash_address == $past(o_flash_address) + 32'd4)
        else $error("flash address did not advance by one word");

endmodule

bind hex_record_to_flash_words_unit hrfw_checker u_hrfw_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_word_valid     (o_word_valid),
    .i_word_ready     (i_word_ready),
    .o_flash_address  (o_flash_address),
    .o_data_word      (o_data_word),
    .o_last_of_record (o_last_of_record)
);
